// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame parser RTL.
// Depends on nothing; included inside module bodies that have clock and reset ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ubx_pkg.sv =====
// Shared types and constants for the frame parser.
// Depends on nothing; imported by ubx_parse_core and ubx_frame_parser_top.
`default_nettype none

package ubx_pkg;

   // Sync pair that opens every frame.
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   // Parser phases. Codes that are not listed behave as hunting.
   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_SYNC1   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_MSGID   = 4'd3,
      PH_LENLO   = 4'd4,
      PH_PAYLOAD = 4'd5,
      PH_CKA     = 4'd6,
      PH_CKB     = 4'd7,
      PH_LENHI   = 4'd8
   } phase_type;

   // Per-byte frame status.
   typedef enum logic [1:0] {
      ST_INCOMPLETE = 2'd0,
      ST_GOOD       = 2'd1,
      ST_BAD        = 2'd2
   } status_type;

   // One result of the parser.
   typedef struct packed {
      status_type  frame_status;
      logic [7:0]  msg_class;
      logic [7:0]  message_id;
      logic [15:0] payload_length;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/ubx_frame_parser_top.sv =====
// Bytes wait in the input register; each result is loaded into the result register.
// Throughput: one byte per cycle unless rsp_stall holds; the input and result registers
// each take a new transfer as the next stage moves on, so stalls cost no extra bubbles.
// Each byte is handled by the phase state machine and checksum adders.
// Reset (synchronous, active high) empties both registers and returns to hunting for sync.
`default_nettype none

module ubx_frame_parser_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_frame_status,
   output      logic [7:0]  rsp_msg_class,
   output      logic [7:0]  rsp_message_id,
   output      logic [15:0] rsp_payload_length,
   output      logic        rsp_payload_valid,
   output      logic [7:0]  rsp_payload_byte,
   output      logic [15:0] rsp_payload_index
);
   import ubx_pkg::*;

   `include "assert_macros.svh"

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type step_result;
   logic       advance;
   logic       req_take;

   // The input byte moves on when the result register is empty or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ubx_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .result  (step_result)
   );

   // Occupancy of the input and result registers.
   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load on each transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_status   = rsp_ff.frame_status;
   assign rsp_msg_class      = rsp_ff.msg_class;
   assign rsp_message_id     = rsp_ff.message_id;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_payload_valid  = rsp_ff.payload_valid;
   assign rsp_payload_byte   = rsp_ff.payload_byte;
   assign rsp_payload_index  = rsp_ff.payload_index;

   // The input side is held off only while a byte waits in the input register.
   `ASSERT_IMPLIES(a_stall_full, req_stall, in_valid_ff, "input stalled while empty")
   // A processed byte always leaves a result behind.
   `ASSERT_NEXT(a_advance_result, advance, rsp_valid_ff, "processed byte lost its result")
   // A stalled result stays offered and unchanged.
   `ASSERT_NEXT(a_rsp_hold, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_ff), "stalled result changed")

endmodule

`default_nettype wire

// ===== rtl/ubx_parse_core.sv =====
// Frame parser state machine, frame registers and running Fletcher checksum.
// Depends on ubx_pkg and assert_macros.svh.
`default_nettype none

module ubx_parse_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step_en,
   input  wire logic [7:0]         rx_byte,
   output ubx_pkg::result_type     result
);
   import ubx_pkg::*;

   `include "assert_macros.svh"

   phase_type   phase_ff, phase_in;
   logic [7:0]  class_ff, class_in;
   logic [7:0]  msg_ff, msg_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] index_ff, index_in;
   logic [7:0]  sum_a_ff, sum_a_in;
   logic [7:0]  sum_b_ff, sum_b_in;
   logic [7:0]  check_ff, check_in;
   logic [7:0]  add_a;
   logic [7:0]  add_b;
   logic [15:0] index_inc;
   logic        pay_out;
   logic        sts_out;

   // Fletcher step over the current byte and the incremented payload index.
   assign add_a     = sum_a_ff + rx_byte;
   assign add_b     = sum_b_ff + add_a;
   assign index_inc = index_ff + 16'd1;

   // Next phase.
   always_comb begin
      unique case (phase_ff)
         PH_SYNC1:   phase_in = (rx_byte == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
         PH_CLASS:   phase_in = PH_MSGID;
         PH_MSGID:   phase_in = PH_LENLO;
         PH_LENLO:   phase_in = PH_LENHI;
         PH_LENHI:   phase_in = ({rx_byte, length_ff[7:0]} == 16'd0) ? PH_CKA : PH_PAYLOAD;
         PH_PAYLOAD: phase_in = (index_inc == length_ff) ? PH_CKA : PH_PAYLOAD;
         PH_CKA:     phase_in = PH_CKB;
         PH_CKB:     phase_in = PH_HUNT;
         default:    phase_in = (rx_byte == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
      endcase
   end

   // Frame fields, checksum and the result for this byte.
   always_comb begin
      class_in  = class_ff;
      msg_in    = msg_ff;
      length_in = length_ff;
      index_in  = index_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      check_in  = check_ff;
      result    = '0;
      unique case (phase_ff)
         PH_SYNC1: begin
         end
         PH_CLASS: begin
            class_in = rx_byte;
            sum_a_in = rx_byte;
            sum_b_in = rx_byte;
         end
         PH_MSGID: begin
            msg_in   = rx_byte;
            sum_a_in = add_a;
            sum_b_in = add_b;
         end
         PH_LENLO: begin
            length_in = {8'd0, rx_byte};
            sum_a_in  = add_a;
            sum_b_in  = add_b;
         end
         PH_LENHI: begin
            length_in = {rx_byte, length_ff[7:0]};
            sum_a_in  = add_a;
            sum_b_in  = add_b;
            index_in  = 16'd0;
         end
         PH_PAYLOAD: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = index_ff;
            sum_a_in = add_a;
            sum_b_in = add_b;
            index_in = index_inc;
         end
         PH_CKA: begin
            check_in = rx_byte;
         end
         PH_CKB: begin
            result.frame_status = (sum_a_ff == check_ff && sum_b_ff == rx_byte) ?
                                  ST_GOOD : ST_BAD;
         end
         default: begin
            if (rx_byte == SYNC_FIRST) begin
               length_in = 16'd0;
            end
         end
      endcase
      result.msg_class      = class_in;
      result.message_id     = msg_in;
      result.payload_length = length_in;
   end

   // State registers advance once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         class_ff  <= '0;
         msg_ff    <= '0;
         length_ff <= '0;
         index_ff  <= '0;
         sum_a_ff  <= '0;
         sum_b_ff  <= '0;
         check_ff  <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         class_ff  <= class_in;
         msg_ff    <= msg_in;
         length_ff <= length_in;
         index_ff  <= index_in;
         sum_a_ff  <= sum_a_in;
         sum_b_ff  <= sum_b_in;
         check_ff  <= check_in;
      end
   end

   // Processed bytes that carry a payload byte or a final status.
   assign pay_out = step_en && result.payload_valid;
   assign sts_out = step_en && (result.frame_status != ST_INCOMPLETE);

   // Payload bytes come only from the payload phase.
   `ASSERT_IMPLIES(a_pvalid_phase, pay_out, phase_ff == PH_PAYLOAD, "payload outside its phase")
   // A final status is given only on the second check byte.
   `ASSERT_IMPLIES(a_status_phase, sts_out, phase_ff == PH_CKB, "status outside check phase")
   // In the payload phase the index stays below the declared length.
   `ASSERT_IMPLIES(a_index_bound, phase_ff == PH_PAYLOAD, index_ff < length_ff, "index reached length")

endmodule

`default_nettype wire

// ===== bench/frame_check_pkg.sv =====
// Scoreboard for the frame parser: a per-byte model of the parser and a queue of expected results.
// Depends on ubx_pkg for the phase, status and result types and the sync constants.
package frame_check_pkg;
   import ubx_pkg::*;

   class frame_scoreboard;
      // Parser state, kept in step with every accepted byte.
      phase_type   phase;
      logic [7:0]  cls;
      logic [7:0]  msg;
      logic [15:0] length;
      logic [15:0] index;
      logic [7:0]  sum_a;
      logic [7:0]  sum_b;
      logic [7:0]  check_a;

      result_type  expected_q[$];
      int unsigned mismatches;

      function new();
         phase      = PH_HUNT;
         cls        = '0;
         msg        = '0;
         length     = '0;
         index      = '0;
         sum_a      = '0;
         sum_b      = '0;
         check_a    = '0;
         mismatches = 0;
      endfunction

      // Fletcher accumulation over class, id, length and payload.
      function void add_to_sums(logic [7:0] b);
         sum_a = sum_a + b;
         sum_b = sum_b + sum_a;
      endfunction

      // Advance the parser by one accepted byte and queue the result it must produce.
      function void note_byte(logic [7:0] b);
         result_type r;
         r = '0;
         r.frame_status = ST_INCOMPLETE;
         case (phase)
            PH_SYNC1: begin
               phase = (b == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
            end
            PH_CLASS: begin
               cls   = b;
               sum_a = '0;
               sum_b = '0;
               add_to_sums(b);
               phase = PH_MSGID;
            end
            PH_MSGID: begin
               msg = b;
               add_to_sums(b);
               phase = PH_LENLO;
            end
            PH_LENLO: begin
               length = {8'h00, b};
               add_to_sums(b);
               phase = PH_LENHI;
            end
            PH_LENHI: begin
               length[15:8] = b;
               add_to_sums(b);
               index = '0;
               phase = (length == 16'd0) ? PH_CKA : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               r.payload_valid = 1'b1;
               r.payload_byte  = b;
               r.payload_index = index;
               add_to_sums(b);
               index = index + 16'd1;
               if (index == length) phase = PH_CKA;
            end
            PH_CKA: begin
               check_a = b;
               phase   = PH_CKB;
            end
            PH_CKB: begin
               r.frame_status = (sum_a == check_a && sum_b == b) ? ST_GOOD : ST_BAD;
               phase = PH_HUNT;
            end
            default: begin
               // Hunting; unlisted phase codes behave the same way.
               if (b == SYNC_FIRST) begin
                  length = '0;
                  phase  = PH_SYNC1;
               end else begin
                  phase = PH_HUNT;
               end
            end
         endcase
         r.msg_class      = cls;
         r.message_id     = msg;
         r.payload_length = length;
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
            mismatches++;
         end
      endfunction

      // Compare one result transfer with the oldest expectation.
      function void check_result(result_type seen);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("result transfer with no expected result waiting");
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("frame_status", want.frame_status, seen.frame_status);
         compare_field("msg_class", want.msg_class, seen.msg_class);
         compare_field("message_id", want.message_id, seen.message_id);
         compare_field("payload_length", want.payload_length, seen.payload_length);
         compare_field("payload_valid", want.payload_valid, seen.payload_valid);
         compare_field("payload_byte", want.payload_byte, seen.payload_byte);
         compare_field("payload_index", want.payload_index, seen.payload_index);
      endfunction
   endclass

endpackage

// ===== bench/testbench.sv =====
// Top-level bench for ubx_frame_parser_top: drives byte streams of frames, noise and broken
// syncs with random gaps and stalls. Depends on ubx_pkg and frame_check_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ubx_pkg::*;
   import frame_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned RANDOM_ITEMS = 1000;

   // How the two check bytes of a generated frame are damaged.
   typedef enum int {
      CK_INTACT,
      CK_BAD_A,
      CK_BAD_B
   } check_fault_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_frame_status;
   logic [7:0]  rsp_msg_class;
   logic [7:0]  rsp_message_id;
   logic [15:0] rsp_payload_length;
   logic        rsp_payload_valid;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_payload_index;

   frame_scoreboard sb = new();
   bit              tx_idle = 1'b1;
   bit              rx_idle = 1'b1;
   int unsigned     items_sent = 0;
   int unsigned     cycle_count = 0;

   ubx_frame_parser_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_msg_class      (rsp_msg_class),
      .rsp_message_id     (rsp_message_id),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: check each transfer, then hold stall for a drawn number of cycles.
   initial begin
      int unsigned stall_left;
      result_type  seen;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen.frame_status   = status_type'(rsp_frame_status);
            seen.msg_class      = rsp_msg_class;
            seen.message_id     = rsp_message_id;
            seen.payload_length = rsp_payload_length;
            seen.payload_valid  = rsp_payload_valid;
            seen.payload_byte   = rsp_payload_byte;
            seen.payload_index  = rsp_payload_index;
            sb.check_result(seen);
            if (rx_idle) stall_left = $urandom_range(0, 3);
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // Offer one byte after an optional gap and wait for its transfer.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = tx_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
      items_sent++;
   endtask

   // Stop offering bytes until every expected result has been transferred.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // Send a whole frame with a random payload and its checksum, optionally damaged.
   task automatic send_frame(input logic [7:0] cls, input logic [7:0] msg,
                             input logic [15:0] len, input check_fault_type fault);
      logic [7:0] head[4];
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      logic [7:0] b;
      head = '{cls, msg, len[7:0], len[15:8]};
      ck_a = '0;
      ck_b = '0;
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      foreach (head[k]) begin
         send_byte(head[k]);
         ck_a = ck_a + head[k];
         ck_b = ck_b + ck_a;
      end
      for (int i = 0; i < int'(len); i++) begin
         b = 8'($urandom);
         send_byte(b);
         ck_a = ck_a + b;
         ck_b = ck_b + ck_a;
      end
      if (fault == CK_BAD_A) ck_a = ck_a ^ (8'h01 << $urandom_range(0, 7));
      if (fault == CK_BAD_B) ck_b = ck_b ^ (8'h01 << $urandom_range(0, 7));
      send_byte(ck_a);
      send_byte(ck_b);
   endtask

   // Stimulus: directed cases, random traffic, then the verdict.
   initial begin
      int unsigned     frames;
      int unsigned     pick;
      logic [15:0]     len;
      logic [7:0]      b;
      check_fault_type fault;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Noise at both extremes, then a first sync followed by a second first sync.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      // Zero-length frames with good and with bad checksums.
      send_frame(8'h00, 8'hFF, 16'd0, CK_INTACT);
      send_frame(8'hFF, 8'h00, 16'd0, CK_BAD_B);
      // Short frames with a payload.
      send_frame(8'h5A, 8'hA5, 16'd2, CK_INTACT);
      send_frame(8'h01, 8'h80, 16'd1, CK_BAD_A);

      // Let the pipeline empty before random traffic starts.
      wait_drained();

      // Random traffic: mostly well-formed frames, some noise and broken syncs.
      frames = 0;
      while (items_sent < RANDOM_ITEMS) begin
         tx_idle = ($urandom_range(0, 3) != 0);
         rx_idle = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(250, 270))
                                               : 16'($urandom_range(0, 12));
            case ($urandom_range(0, 9))
               0:       fault = CK_BAD_A;
               1:       fault = CK_BAD_B;
               default: fault = CK_INTACT;
            endcase
            send_frame(8'($urandom), 8'($urandom), len, fault);
         end else if (pick < 8) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            // First sync without the second one.
            b = 8'($urandom);
            if (b == SYNC_SECOND) b = ~b;
            send_byte(SYNC_FIRST);
            send_byte(b);
         end
         frames++;
         if (frames % 40 == 0) wait_drained();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
